// File: hdl/cft_pkg.sv
// shared types, sizes and helpers for the chunk frequency table
// no dependencies; used by every module of the block
package cft_pkg;

    localparam int CHUNK_LEN   = 10;
    localparam int TABLE_DEPTH = 256;
    localparam int COUNT_BITS  = 32;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int TOT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W  = $clog2(CHUNK_LEN + 1);
    localparam int WSUM_W = (COUNT_BITS + IDX_W > 33) ? COUNT_BITS + IDX_W : 33;
    localparam int HI_W   = WSUM_W - 32;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_FLUSH = 2'd1,
        OP_WPICK = 2'd2,
        OP_UPICK = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STATUS_INSERTED = 3'd0,
        STATUS_COUNTED  = 3'd1,
        STATUS_DROPPED  = 3'd2,
        STATUS_EMPTY    = 3'd3,
        STATUS_PICKED   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_START,
        S_SEARCH,
        S_DECIDE,
        S_SHIFT,
        S_WRNEW,
        S_MUL1,
        S_MUL2,
        S_WALK,
        S_UNI,
        S_PWAIT,
        S_EMIT
    } state_t;

    typedef logic [CHUNK_LEN-1:0][7:0] key_t;

    typedef struct packed {
        logic [LEN_W-1:0]      len;
        logic [COUNT_BITS-1:0] count;
        key_t                  key;
    } entry_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

    typedef struct packed {
        op_t         operation;
        logic [7:0]  data_byte;
        logic [31:0] random_value;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  entry_index;
        logic [3:0]  key_length;
        logic [7:0]  key_byte;
        logic [31:0] entry_count;
        logic        last;
    } res_t;

    // low eight bits of a table position
    function automatic logic [7:0] idx8(input logic [TOT_W-1:0] p);
        logic [TOT_W+7:0] t;
        t = {8'b0, p};
        return t[7:0];
    endfunction

    // key length widened to the result field
    function automatic logic [3:0] len4(input logic [LEN_W-1:0] l);
        logic [LEN_W+3:0] t;
        t = {4'b0, l};
        return t[3:0];
    endfunction

    // count shown clipped to 32 bits
    function automatic logic [31:0] sat32(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS+31:0] w;
        w = {32'b0, c};
        if (|w[COUNT_BITS+31:32])
        begin
            return '1;
        end
        return w[31:0];
    endfunction

endpackage

// File: hdl/cft_key_cmp.sv
// lexicographic compare of one stored key against the chunk buffer
// depends on cft_pkg
module cft_key_cmp (
    input  cft_pkg::entry_t              row,
    input  cft_pkg::key_t                chunk,
    input  logic [cft_pkg::LEN_W-1:0]    fill,
    output cft_pkg::cmp_t                cmp
);
    import cft_pkg::*;

    logic [LEN_W-1:0] n;
    logic             found;
    logic             lt_byte;

    // first differing byte within the shorter key decides, else length does
    always_comb
    begin
        n       = (row.len < fill) ? row.len : fill;
        found   = 1'b0;
        lt_byte = 1'b0;
        for (int i = 0; i < CHUNK_LEN; i++)
        begin
            if (!found && (LEN_W'(i) < n) && (row.key[i] != chunk[i]))
            begin
                found   = 1'b1;
                lt_byte = row.key[i] < chunk[i];
            end
        end
        if (found)
        begin
            cmp.lt = lt_byte;
            cmp.eq = 1'b0;
        end
        else
        begin
            cmp.lt = row.len < fill;
            cmp.eq = row.len == fill;
        end
    end

endmodule

// File: hdl/chunk_frequency_table_with_weighted_pick.sv
// chunk frequency table with weighted and uniform pick; one word at a time.
// add without commit: stays idle. commit: search the sorted table, then count, drop, or
// shift up later entries and write the chunk, one entry read or moved a cycle by the memory.
// weighted pick: two multiply steps and a walk; uniform pick: a read; then a word per byte.
// results leave one a cycle with no stall; asynchronous active-low reset empties the table.
module chunk_frequency_table_with_weighted_pick (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cft_pkg::cmd_t command,
    output cft_pkg::res_t result,
    output logic          result_strobe
);
    import cft_pkg::*;

    state_t                state_reg, state_next;
    logic [LEN_W-1:0]      fill_reg, fill_next;
    key_t                  chunk_reg, chunk_next;
    logic [TOT_W-1:0]      total_reg, total_next;
    logic [WSUM_W-1:0]     wsum_reg, wsum_next;
    logic [TOT_W-1:0]      pos_reg, pos_next;
    logic [TOT_W-1:0]      sh_reg, sh_next;
    logic [31:0]           rnd_reg, rnd_next;
    logic [63:0]           prod_lo_reg, prod_lo_next;
    logic [31+HI_W:0]      prod_hi_reg, prod_hi_next;
    logic [31+TOT_W:0]     uprod_reg, uprod_next;
    logic [WSUM_W-1:0]     target_reg, target_next;
    logic [WSUM_W-1:0]     run_reg, run_next;
    logic [LEN_W-1:0]      bidx_reg, bidx_next;
    res_t                  res_reg, res_next;
    logic                  strobe_reg, strobe_next;

    entry_t                mem [TABLE_DEPTH];
    entry_t                rd_data_reg;
    logic                  rd_en, wr_en;
    logic [IDX_W-1:0]      rd_addr, wr_addr;
    entry_t                wr_data;

    cmp_t                  cmp;
    logic [TOT_W-1:0]      pos_inc;
    logic [LEN_W-1:0]      add_fill;
    logic [WSUM_W-1:0]     run_sum;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [7:0]            pick_byte;

    cft_key_cmp u_cmp (
        .row   (rd_data_reg),
        .chunk (chunk_reg),
        .fill  (fill_reg),
        .cmp   (cmp)
    );

    assign busy          = state_reg != S_IDLE;
    assign result        = res_reg;
    assign result_strobe = strobe_reg;

    // entry memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            total_reg  <= '0;
            wsum_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            total_reg  <= total_next;
            wsum_reg   <= wsum_next;
            strobe_reg <= strobe_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        chunk_reg   <= chunk_next;
        pos_reg     <= pos_next;
        sh_reg      <= sh_next;
        rnd_reg     <= rnd_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        uprod_reg   <= uprod_next;
        target_reg  <= target_next;
        run_reg     <= run_next;
        bidx_reg    <= bidx_next;
        res_reg     <= res_next;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        chunk_next   = chunk_reg;
        total_next   = total_reg;
        wsum_next    = wsum_reg;
        pos_next     = pos_reg;
        sh_next      = sh_reg;
        rnd_next     = rnd_reg;
        prod_lo_next = prod_lo_reg;
        prod_hi_next = prod_hi_reg;
        uprod_next   = uprod_reg;
        target_next  = target_reg;
        run_next     = run_reg;
        bidx_next    = bidx_reg;
        res_next     = res_reg;
        strobe_next  = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = pos_reg[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = pos_reg[IDX_W-1:0];
        wr_data      = rd_data_reg;

        pos_inc  = pos_reg + 1'b1;
        add_fill = (fill_reg < LEN_W'(CHUNK_LEN)) ? fill_reg + 1'b1 : fill_reg;
        run_sum  = run_reg + WSUM_W'(rd_data_reg.count);
        cnt_inc  = (&rd_data_reg.count) ? rd_data_reg.count : rd_data_reg.count + 1'b1;

        pick_byte = 8'd0;
        for (int i = 0; i < CHUNK_LEN; i++)
        begin
            if (bidx_reg == LEN_W'(i))
            begin
                pick_byte = rd_data_reg.key[i];
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rnd_next   = command.random_value;
                    uprod_next = (32+TOT_W)'(command.random_value) * (32+TOT_W)'(total_reg);
                    case (command.operation)
                        OP_ADD:
                        begin
                            for (int i = 0; i < CHUNK_LEN; i++)
                            begin
                                if ((fill_reg == LEN_W'(i)) && (fill_reg < LEN_W'(CHUNK_LEN)))
                                begin
                                    chunk_next[i] = command.data_byte;
                                end
                            end
                            fill_next = add_fill;
                            if (add_fill >= LEN_W'(CHUNK_LEN))
                            begin
                                state_next = S_SRCH_START;
                            end
                        end
                        OP_FLUSH:
                        begin
                            if (fill_reg != '0)
                            begin
                                state_next = S_SRCH_START;
                            end
                        end
                        default:
                        begin
                            if (total_reg == '0)
                            begin
                                res_next             = '0;
                                res_next.status      = STATUS_EMPTY;
                                res_next.last        = 1'b1;
                                strobe_next          = 1'b1;
                            end
                            else if (command.operation == OP_WPICK)
                            begin
                                state_next = S_MUL1;
                            end
                            else
                            begin
                                state_next = S_UNI;
                            end
                        end
                    endcase
                end
            end

            // commit: walk the sorted table for the chunk's place
            S_SRCH_START:
            begin
                pos_next = '0;
                if (total_reg == '0)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                if (cmp.eq)
                begin
                    wr_en         = 1'b1;
                    wr_data.count = cnt_inc;
                    if (!(&rd_data_reg.count))
                    begin
                        wsum_next = wsum_reg + 1'b1;
                    end
                    res_next.status      = STATUS_COUNTED;
                    res_next.entry_index = idx8(pos_reg);
                    res_next.key_length  = len4(fill_reg);
                    res_next.key_byte    = 8'd0;
                    res_next.entry_count = sat32(cnt_inc);
                    res_next.last        = 1'b1;
                    strobe_next          = 1'b1;
                    fill_next            = '0;
                    state_next           = S_IDLE;
                end
                else if (!cmp.lt)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    pos_next = pos_inc;
                    if (pos_inc == total_reg)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = pos_inc[IDX_W-1:0];
                    end
                end
            end

            S_DECIDE:
            begin
                if (total_reg >= TOT_W'(TABLE_DEPTH))
                begin
                    res_next.status      = STATUS_DROPPED;
                    res_next.entry_index = 8'd0;
                    res_next.key_length  = len4(fill_reg);
                    res_next.key_byte    = 8'd0;
                    res_next.entry_count = 32'd0;
                    res_next.last        = 1'b1;
                    strobe_next          = 1'b1;
                    fill_next            = '0;
                    state_next           = S_IDLE;
                end
                else if (pos_reg == total_reg)
                begin
                    state_next = S_WRNEW;
                end
                else
                begin
                    sh_next    = total_reg;
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(total_reg - 1'b1);
                    state_next = S_SHIFT;
                end
            end

            // move entries up by one, highest first, read one ahead
            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = sh_reg[IDX_W-1:0];
                sh_next = sh_reg - 1'b1;
                if ((sh_reg - 1'b1) == pos_reg)
                begin
                    state_next = S_WRNEW;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(sh_reg - TOT_W'(2));
                end
            end

            S_WRNEW:
            begin
                wr_en          = 1'b1;
                wr_data.len    = fill_reg;
                wr_data.count  = COUNT_BITS'(1);
                wr_data.key    = chunk_reg;
                total_next     = total_reg + 1'b1;
                wsum_next      = wsum_reg + 1'b1;
                res_next.status      = STATUS_INSERTED;
                res_next.entry_index = idx8(pos_reg);
                res_next.key_length  = len4(fill_reg);
                res_next.key_byte    = 8'd0;
                res_next.entry_count = 32'd1;
                res_next.last        = 1'b1;
                strobe_next          = 1'b1;
                fill_next            = '0;
                state_next           = S_IDLE;
            end

            // weighted pick: target from two partial products
            S_MUL1:
            begin
                prod_lo_next = 64'(rnd_reg) * 64'(wsum_reg[31:0]);
                prod_hi_next = (32+HI_W)'(rnd_reg) * (32+HI_W)'(wsum_reg[WSUM_W-1:32]);
                state_next   = S_MUL2;
            end

            S_MUL2:
            begin
                target_next = WSUM_W'(prod_hi_reg) + WSUM_W'(prod_lo_reg[63:32]);
                run_next    = '0;
                pos_next    = '0;
                rd_en       = 1'b1;
                rd_addr     = '0;
                state_next  = S_WALK;
            end

            S_WALK:
            begin
                run_next = run_sum;
                if (run_sum > target_reg)
                begin
                    bidx_next  = '0;
                    state_next = S_EMIT;
                end
                else if (pos_inc == total_reg)
                begin
                    pos_next   = '0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = S_PWAIT;
                end
                else
                begin
                    pos_next = pos_inc;
                    rd_en    = 1'b1;
                    rd_addr  = pos_inc[IDX_W-1:0];
                end
            end

            S_UNI:
            begin
                pos_next   = uprod_reg[31+TOT_W:32];
                rd_en      = 1'b1;
                rd_addr    = uprod_reg[31+IDX_W:32];
                state_next = S_PWAIT;
            end

            S_PWAIT:
            begin
                bidx_next  = '0;
                state_next = S_EMIT;
            end

            // one key byte per word
            S_EMIT:
            begin
                res_next.status      = STATUS_PICKED;
                res_next.entry_index = idx8(pos_reg);
                res_next.key_length  = len4(rd_data_reg.len);
                res_next.key_byte    = pick_byte;
                res_next.entry_count = sat32(rd_data_reg.count);
                res_next.last        = (bidx_reg + 1'b1) == rd_data_reg.len;
                strobe_next          = 1'b1;
                bidx_next            = bidx_reg + 1'b1;
                if ((bidx_reg + 1'b1) == rd_data_reg.len)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/cft_checker.sv
// port-level checks for the chunk frequency table, bound to the top level
// depends on cft_pkg
module cft_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input cft_pkg::res_t result,
    input logic          result_strobe
);
    import cft_pkg::*;

    // a word only follows work in progress or an accepted command
    a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> ($past(busy) || $past(start && !busy)))
        else $error("result word without a command");

    // a word that is not the last keeps the block busy
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last) |-> busy)
        else $error("block idle before the last word");

    // pick bytes follow one another without a gap
    a_pick_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last) |=>
            (result_strobe && result.status == STATUS_PICKED))
        else $error("gap in picked key bytes");

    // an empty table answers with a single bare word
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.status == STATUS_EMPTY) |->
            (result.last && result.entry_count == 32'd0 && result.key_length == 4'd0))
        else $error("malformed empty-table word");

endmodule

bind chunk_frequency_table_with_weighted_pick cft_checker u_cft_checker (.*);

// File: test/chunk_frequency_table_with_weighted_pick_test.sv
// self-checking bench for the chunk frequency table with weighted and uniform pick
// depends on cft_pkg and chunk_frequency_table_with_weighted_pick; drives command words
module chunk_frequency_table_with_weighted_pick_test;
    import cft_pkg::*;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    cmd_t  command = '0;
    res_t  result;
    logic  result_strobe;

    chunk_frequency_table_with_weighted_pick u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .result        (result),
        .result_strobe (result_strobe)
    );

    always #10 clk = ~clk;

    // shadow copy of the table
    logic [7:0]  chunk_bytes [CHUNK_LEN];
    int unsigned chunk_len_now;
    int unsigned table_size;
    logic [7:0]  shadow_key [TABLE_DEPTH][CHUNK_LEN];
    int unsigned shadow_len [TABLE_DEPTH];
    logic [31:0] shadow_cnt [TABLE_DEPTH];
    logic [63:0] total_weight;

    res_t        pending_words [$];
    int          mismatches;
    int          send_gap_pct;

    // queue one expected word at the tail
    function automatic void expect_word(res_t w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    // expected word builder
    function automatic res_t mk(status_t st, int unsigned idx, int unsigned len,
                                logic [7:0] b, logic [31:0] cnt, logic lst);
        res_t r;
        r.status      = st;
        r.entry_index = idx[7:0];
        r.key_length  = len[3:0];
        r.key_byte    = b;
        r.entry_count = cnt;
        r.last        = lst;
        return r;
    endfunction

    // compare shadow entry with current chunk: -1 before, 0 equal, 1 after
    function automatic int order_vs_chunk(int unsigned e);
        int unsigned n;
        n = (shadow_len[e] < chunk_len_now) ? shadow_len[e] : chunk_len_now;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (shadow_key[e][i] != chunk_bytes[i])
            begin
                return (shadow_key[e][i] < chunk_bytes[i]) ? -1 : 1;
            end
        end
        if (shadow_len[e] == chunk_len_now)
        begin
            return 0;
        end
        return (shadow_len[e] < chunk_len_now) ? -1 : 1;
    endfunction

    task automatic commit_chunk();
        int unsigned pos;
        int          c;
        pos = 0;
        c = 1;
        while (pos < table_size)
        begin
            c = order_vs_chunk(pos);
            if (c >= 0)
            begin
                break;
            end
            pos++;
        end
        if (pos < table_size && c == 0)
        begin
            if (shadow_cnt[pos] != 32'hFFFF_FFFF)
            begin
                shadow_cnt[pos]++;
                total_weight++;
            end
            expect_word(mk(STATUS_COUNTED, pos, chunk_len_now, 8'd0,
                           shadow_cnt[pos], 1'b1));
        end
        else if (table_size >= TABLE_DEPTH)
        begin
            expect_word(mk(STATUS_DROPPED, 0, chunk_len_now, 8'd0, 32'd0, 1'b1));
        end
        else
        begin
            for (int unsigned e = table_size; e > pos; e--)
            begin
                shadow_key[e] = shadow_key[e-1];
                shadow_len[e] = shadow_len[e-1];
                shadow_cnt[e] = shadow_cnt[e-1];
            end
            for (int unsigned i = 0; i < CHUNK_LEN; i++)
            begin
                shadow_key[pos][i] = chunk_bytes[i];
            end
            shadow_len[pos] = chunk_len_now;
            shadow_cnt[pos] = 32'd1;
            table_size++;
            total_weight++;
            expect_word(mk(STATUS_INSERTED, pos, chunk_len_now, 8'd0, 32'd1, 1'b1));
        end
        chunk_len_now = 0;
    endtask

    task automatic emit_key(int unsigned e);
        for (int unsigned i = 0; i < shadow_len[e]; i++)
        begin
            expect_word(mk(STATUS_PICKED, e, shadow_len[e], shadow_key[e][i],
                           shadow_cnt[e], i + 1 == shadow_len[e]));
        end
    endtask

    // work out the words one command causes
    task automatic predict_table(cmd_t cm);
        logic [63:0] target;
        logic [63:0] run;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] uprod;
        int unsigned e;
        bit          found;
        case (cm.operation)
            OP_ADD:
            begin
                if (chunk_len_now < CHUNK_LEN)
                begin
                    chunk_bytes[chunk_len_now] = cm.data_byte;
                    chunk_len_now++;
                end
                if (chunk_len_now >= CHUNK_LEN)
                begin
                    commit_chunk();
                end
            end
            OP_FLUSH:
            begin
                if (chunk_len_now != 0)
                begin
                    commit_chunk();
                end
            end
            default:
            begin
                if (table_size == 0)
                begin
                    expect_word(mk(STATUS_EMPTY, 0, 0, 8'd0, 32'd0, 1'b1));
                end
                else if (cm.operation == OP_WPICK)
                begin
                    // target split in two halves so the product never overflows
                    hi = total_weight >> 32;
                    lo = total_weight & 64'h0000_0000_FFFF_FFFF;
                    target = {32'd0, cm.random_value} * hi
                           + (({32'd0, cm.random_value} * lo) >> 32);
                    run = 0;
                    found = 0;
                    for (e = 0; e < table_size && !found; e++)
                    begin
                        run += shadow_cnt[e];
                        if (run > target)
                        begin
                            emit_key(e);
                            found = 1;
                        end
                    end
                    if (!found)
                    begin
                        emit_key(0);
                    end
                end
                else
                begin
                    uprod = {32'd0, cm.random_value} * 64'(table_size);
                    e = uprod[63:32];
                    if (e >= table_size)
                    begin
                        e = table_size - 1;
                    end
                    emit_key(e);
                end
            end
        endcase
    endtask

    // result checking at the rising edge
    always @(posedge clk)
    begin
        res_t ex;
        if (rst_n && result_strobe)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected word %p", result);
                end
            end
            else
            begin
                ex = pending_words.pop_front();
                if (result !== ex)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected %p got %p", ex, result);
                    end
                end
            end
        end
    end

    // drive one command word, idling first at the chosen rate
    task automatic send_word(op_t op, logic [7:0] b, logic [31:0] rv);
        cmd_t cm;
        while ($urandom_range(99) < send_gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        cm.operation    = op;
        cm.data_byte    = b;
        cm.random_value = rv;
        command <= cm;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        predict_table(cm);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // directed stimulus: operation, byte, random value
    typedef struct {
        op_t         op;
        logic [7:0]  b;
        logic [31:0] rv;
    } row_t;

    row_t directed [] = '{
        '{OP_WPICK, 8'h00, 32'h0000_0000},
        '{OP_UPICK, 8'hFF, 32'hFFFF_FFFF},
        '{OP_FLUSH, 8'h00, 32'h0},
        '{OP_ADD,   8'hFF, 32'h0},
        '{OP_FLUSH, 8'h00, 32'h0},
        '{OP_ADD,   8'h00, 32'h0},
        '{OP_FLUSH, 8'h00, 32'h0},
        '{OP_ADD,   8'hFF, 32'h0},
        '{OP_FLUSH, 8'h00, 32'h0},
        '{OP_ADD,   8'h00, 32'h0},
        '{OP_ADD,   8'hFF, 32'h0},
        '{OP_FLUSH, 8'h00, 32'h0},
        '{OP_WPICK, 8'h00, 32'hFFFF_FFFF},
        '{OP_WPICK, 8'h00, 32'h0000_0000},
        '{OP_UPICK, 8'h00, 32'h0000_0000},
        '{OP_UPICK, 8'h00, 32'h8000_0000},
        '{OP_WPICK, 8'h00, 32'h5555_5555}
    };

    logic [7:0] motif [4][CHUNK_LEN];

    initial
    begin
        int n;
        table_size = 0;
        chunk_len_now = 0;
        total_weight = 0;
        mismatches = 0;
        send_gap_pct = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table picks must report empty
        foreach (directed[i])
        begin
            if (i < 2)
            begin
                expect_word(mk(STATUS_EMPTY, 0, 0, 8'd0, 32'd0, 1'b1));
                send_word(directed[i].op, directed[i].b, directed[i].rv);
                pending_words.delete(pending_words.size() - 1);
            end
            else
            begin
                send_word(directed[i].op, directed[i].b, directed[i].rv);
            end
        end
        // one full chunk of alternating 0x55 and 0xAA bytes
        for (int i = 0; i < CHUNK_LEN; i++)
        begin
            send_word(OP_ADD, (i % 2) ? 8'hAA : 8'h55, 32'h0);
        end
        wait_drained();

        // random phases with repeated chunks so counts grow
        foreach (motif[m, j])
        begin
            motif[m][j] = 8'($urandom_range(3));
        end
        for (int ph = 0; ph < 4; ph++)
        begin
            send_gap_pct = (ph == 1) ? 77 : (ph == 3) ? 17 : 0;
            n = 0;
            while (n < 85)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3:
                    begin
                        int m;
                        m = $urandom_range(3);
                        for (int j = 0; j < CHUNK_LEN; j++)
                        begin
                            send_word(OP_ADD, motif[m][j], $urandom);
                        end
                        n += CHUNK_LEN;
                    end
                    4:
                    begin
                        repeat ($urandom_range(1, 4))
                        begin
                            send_word(OP_ADD,
                                      8'(($urandom_range(3) == 0) ? $urandom
                                                                  : $urandom_range(2)),
                                      $urandom);
                            n++;
                        end
                        send_word(OP_FLUSH, 8'($urandom), $urandom);
                        n++;
                    end
                    5, 6:
                    begin
                        send_word(OP_WPICK, 8'($urandom), $urandom);
                        n++;
                    end
                    7:
                    begin
                        send_word(OP_UPICK, 8'($urandom), $urandom);
                        n++;
                    end
                    default:
                    begin
                        send_word(OP_ADD, 8'($urandom), $urandom);
                        n++;
                    end
                endcase
            end
            // hold the sender until every word is back
            wait_drained();
            repeat (600) @(negedge clk);
        end

        // a last commit and picks at the top of the random range
        send_gap_pct = 0;
        send_word(OP_ADD, 8'hEE, 32'h0);
        send_word(OP_FLUSH, 8'h00, 32'h0);
        send_word(OP_WPICK, 8'h00, 32'hFFFF_FFFF);
        send_word(OP_UPICK, 8'h00, 32'hFFFF_FFFF);
        wait_drained();
        repeat (600) @(negedge clk);

        if (mismatches == 0 && pending_words.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
